@@ rtl/bldc_bemf_six_step_commutator_defines.svh @@
// Assertion macros used by the commutator top level.
`ifndef BLDC_BEMF_SIX_STEP_COMMUTATOR_DEFINES_SVH
`define BLDC_BEMF_SIX_STEP_COMMUTATOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define BBSC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BBSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bbsc_pkg.sv @@
// Types, constants and tables of the six-step back-EMF commutator.
package bbsc_pkg;

    localparam int POS_W      = 3;
    localparam int DRIVE_W    = 3;
    localparam int DELAY_W    = 8;
    localparam int DUTY_W     = 10;
    localparam int BEMF_W     = 3;
    localparam int CFG_IDX_W  = 4;

    localparam int COUNT_BITS_DEF = 8;
    localparam int ELAPSED_CLAMP  = 40;

    localparam logic [POS_W-1:0]   POSITION_RESET = 3'd1;
    localparam int                 ELAPSED_RESET  = 50;
    localparam logic [DELAY_W-1:0] DELAY_RESET    = 8'd20;
    localparam logic [DRIVE_W-1:0] DRIVE_RESET    = 3'd0;
    localparam logic [DUTY_W-1:0]  DUTY_RESET     = 10'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LEVEL = 4'd1;

    localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 3'd6;

    localparam logic [BEMF_W-1:0] PHASE_A = 3'h1;
    localparam logic [BEMF_W-1:0] PHASE_B = 3'h2;
    localparam logic [BEMF_W-1:0] PHASE_C = 3'h4;
    localparam logic [BEMF_W-1:0] LEVEL_LOW = 3'h0;

    localparam logic [2:0] HALL_MAP [8] = '{3'd0, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd0};
    localparam logic [2:0] FWD_PHASE [8] = '{3'd0, 3'd1, 3'd6, 3'd5, 3'd2, 3'd4, 3'd3, 3'd0};
    localparam logic [2:0] REV_PHASE [8] = '{3'd0, 3'd5, 3'd4, 3'd1, 3'd3, 3'd6, 3'd2, 3'd0};

    localparam logic [BEMF_W-1:0] CW_MASK [8] =
        '{LEVEL_LOW, PHASE_B, PHASE_C, PHASE_A, PHASE_B, PHASE_C, PHASE_A, LEVEL_LOW};
    localparam logic [BEMF_W-1:0] CW_LEVEL [8] =
        '{LEVEL_LOW, LEVEL_LOW, PHASE_C, LEVEL_LOW, PHASE_B, LEVEL_LOW, PHASE_A, LEVEL_LOW};
    localparam logic [BEMF_W-1:0] CCW_MASK [8] =
        '{LEVEL_LOW, PHASE_C, PHASE_B, PHASE_A, PHASE_C, PHASE_B, PHASE_A, LEVEL_LOW};
    localparam logic [BEMF_W-1:0] CCW_LEVEL [8] =
        '{LEVEL_LOW, LEVEL_LOW, PHASE_B, LEVEL_LOW, PHASE_C, LEVEL_LOW, PHASE_A, LEVEL_LOW};

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [DELAY_W-1:0] delay_count;
        logic [DRIVE_W-1:0] drive;
    } rotor_state_t;

endpackage

@@ rtl/bbsc_step.sv @@
// Next-state logic for one item: tick counting, back-EMF match and delay update.
module bbsc_step #(
    parameter int COUNT_BITS = bbsc_pkg::COUNT_BITS_DEF
) (
    input  bbsc_pkg::rotor_state_t           cur_state,
    input  logic [COUNT_BITS-1:0]            elapsed,
    input  logic                             direction,
    input  logic                             action,
    input  logic [bbsc_pkg::BEMF_W-1:0]      bemf_bits,
    output bbsc_pkg::rotor_state_t           next_state,
    output logic [COUNT_BITS-1:0]            elapsed_next,
    output logic                             commutated
);

    localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CMP_W-1:0] CLAMP = CMP_W'(bbsc_pkg::ELAPSED_CLAMP);

    logic [bbsc_pkg::BEMF_W-1:0]  watch_mask;
    logic [bbsc_pkg::BEMF_W-1:0]  watch_level;
    logic                         pos_valid;
    logic [CMP_W-1:0]             ticks_ext;
    logic [CMP_W-1:0]             ticks_clamped;
    logic [bbsc_pkg::DELAY_W-1:0] half;
    logic [bbsc_pkg::DELAY_W-1:0] delay_cur;
    logic [2:0]                   hall;

    assign watch_mask  = direction ? bbsc_pkg::CCW_MASK[cur_state.position]
                                   : bbsc_pkg::CW_MASK[cur_state.position];
    assign watch_level = direction ? bbsc_pkg::CCW_LEVEL[cur_state.position]
                                   : bbsc_pkg::CW_LEVEL[cur_state.position];
    assign pos_valid   = (cur_state.position >= bbsc_pkg::POS_FIRST) &&
                         (cur_state.position <= bbsc_pkg::POS_LAST);

    assign ticks_ext     = CMP_W'(elapsed);
    assign ticks_clamped = (ticks_ext > CLAMP) ? CLAMP : ticks_ext;
    assign half          = bbsc_pkg::DELAY_W'(ticks_clamped >> 1);
    assign delay_cur     = cur_state.delay_count;
    assign hall          = bbsc_pkg::HALL_MAP[cur_state.position];

    always_comb begin
        next_state   = cur_state;
        elapsed_next = elapsed;
        commutated   = 1'b0;
        if (action) begin
            if (elapsed != COUNT_MAX) begin
                elapsed_next = elapsed + 1'b1;
            end
        end else if (pos_valid && ((bemf_bits & watch_mask) == watch_level)) begin
            commutated      = 1'b1;
            elapsed_next    = '0;
            next_state.drive = direction ? bbsc_pkg::REV_PHASE[hall]
                                         : bbsc_pkg::FWD_PHASE[hall];
            next_state.position = (cur_state.position == bbsc_pkg::POS_LAST)
                                  ? bbsc_pkg::POS_FIRST
                                  : cur_state.position + 1'b1;
            priority if (delay_cur < half) begin
                next_state.delay_count = delay_cur + 1'b1;
            end else if ((delay_cur > half) && (delay_cur > 8'd1)) begin
                next_state.delay_count = delay_cur - 1'b1;
            end else begin
                next_state.delay_count = delay_cur;
            end
        end
    end

endmodule

@@ rtl/bldc_bemf_six_step_commutator.sv @@
// Top level of the sensorless six-step BLDC back-EMF commutator.
// Takes one item per clock: s_tready is high whenever the result register is
// empty or its item is taken in the same cycle, so a steady stream moves at
// one item a cycle. Each accepted item yields exactly one result item in the
// next cycle, held in the single result register until m_tready. The state
// update for an item is one pass of table lookups and an 8-bit compare.
// Configuration writes are taken at once (cfg_ready is always high).
`include "bldc_bemf_six_step_commutator_defines.svh"

module bldc_bemf_six_step_commutator #(
    parameter int COUNT_BITS = bbsc_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [2:0] bemf_bits
    input  logic [0:0]                       s_tuser,  // [0] action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] drive_step, [5:3] rotor_position, [13:6] delay_estimate, [23:14] duty_out
    output logic [23:0]                      m_tdata,
    output logic [0:0]                       m_tuser,  // [0] commutated
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbsc_pkg::DUTY_W-1:0]      cfg_data
);

    logic                         direction_reg;
    logic [bbsc_pkg::DUTY_W-1:0]  duty_reg;
    bbsc_pkg::rotor_state_t       state_reg;
    bbsc_pkg::rotor_state_t       state_next;
    logic [COUNT_BITS-1:0]        elapsed_reg;
    logic [COUNT_BITS-1:0]        elapsed_next;
    logic                         commutated_next;
    logic                         s_accept;
    logic                         cfg_accept;

    logic                         out_valid_reg;
    logic                         out_commutated_reg;
    bbsc_pkg::rotor_state_t       out_state_reg;
    logic [bbsc_pkg::DUTY_W-1:0]  out_duty_reg;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = !out_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;

    bbsc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cur_state    (state_reg),
        .elapsed      (elapsed_reg),
        .direction    (direction_reg),
        .action       (s_tuser[0]),
        .bemf_bits    (s_tdata[2:0]),
        .next_state   (state_next),
        .elapsed_next (elapsed_next),
        .commutated   (commutated_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            duty_reg      <= bbsc_pkg::DUTY_RESET;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                bbsc_pkg::CFG_DIRECTION:  direction_reg <= cfg_data[0];
                bbsc_pkg::CFG_DUTY_LEVEL: duty_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.position    <= bbsc_pkg::POSITION_RESET;
            state_reg.delay_count <= bbsc_pkg::DELAY_RESET;
            state_reg.drive       <= bbsc_pkg::DRIVE_RESET;
            elapsed_reg           <= COUNT_BITS'(bbsc_pkg::ELAPSED_RESET);
        end else if (s_accept) begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_commutated_reg <= commutated_next;
            out_state_reg      <= state_next;
            out_duty_reg       <= duty_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_commutated_reg;
    assign m_tdata    = {out_duty_reg, out_state_reg.delay_count,
                         out_state_reg.position, out_state_reg.drive};

    `BBSC_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn,
        m_tvalid && !m_tready, !s_tready, "input taken while result stalled")
    `BBSC_ASSERT_NEXT(a_tick_holds_position, aclk, aresetn,
        s_accept && s_tuser[0], state_reg == $past(state_reg),
        "tick changed rotor state")
    `BBSC_ASSERT_NEXT(a_commutation_clears_ticks, aclk, aresetn,
        s_accept && commutated_next, elapsed_reg == '0,
        "tick counter not cleared on commutation")
    `BBSC_ASSERT_NEXT(a_delay_moves_by_one, aclk, aresetn,
        s_accept,
        (state_reg.delay_count == $past(state_reg.delay_count)) ||
        (state_reg.delay_count == $past(state_reg.delay_count) + 8'd1) ||
        (state_reg.delay_count == $past(state_reg.delay_count) - 8'd1),
        "delay estimate jumped by more than one")

endmodule

@@ test/bldc_bemf_six_step_commutator_tb.sv @@
// Self-checking testbench for the six-step back-EMF commutator: directed and random streams.
`timescale 1ns / 100ps

module bldc_bemf_six_step_commutator_tb;

    localparam int   POS_W       = bbsc_pkg::POS_W;
    localparam int   DRIVE_W     = bbsc_pkg::DRIVE_W;
    localparam int   DELAY_W     = bbsc_pkg::DELAY_W;
    localparam int   DUTY_W      = bbsc_pkg::DUTY_W;
    localparam int   BEMF_W      = bbsc_pkg::BEMF_W;
    localparam int   CFG_IDX_W   = bbsc_pkg::CFG_IDX_W;
    localparam int   COUNT_W     = bbsc_pkg::COUNT_BITS_DEF;
    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_TICK    = 1'b1;
    localparam int   HOLD_CYCLES = 300;
    localparam int   STALL_LIMIT = 3000;

    typedef struct packed {
        logic               commutated;
        logic [DRIVE_W-1:0] drive_step;
        logic [POS_W-1:0]   rotor_position;
        logic [DELAY_W-1:0] delay_estimate;
        logic [DUTY_W-1:0]  duty_out;
    } commutation_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;  // [2:0] bemf_bits
    logic [0:0]           s_tuser   = '0;  // [0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [2:0] drive_step, [5:3] rotor_position, [13:6] delay_estimate, [23:14] duty_out
    logic [23:0]          m_tdata;
    logic [0:0]           m_tuser;         // [0] commutated
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUTY_W-1:0]    cfg_data  = '0;

    logic [POS_W-1:0]   rotor_pos   = bbsc_pkg::POSITION_RESET;
    logic [COUNT_W-1:0] rotor_ticks = COUNT_W'(bbsc_pkg::ELAPSED_RESET);
    logic [DELAY_W-1:0] rotor_delay = bbsc_pkg::DELAY_RESET;
    logic [DRIVE_W-1:0] rotor_drive = bbsc_pkg::DRIVE_RESET;
    logic               ccw_sel     = 1'b0;
    logic [DUTY_W-1:0]  duty_reg    = bbsc_pkg::DUTY_RESET;

    commutation_t commutation_q[$];
    int           fault_count = 0;
    bit           no_gaps     = 1'b0;
    bit           hold_req    = 1'b0;
    bit           hold_active = 1'b0;

    bldc_bemf_six_step_commutator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic commutation_t advance_rotor(logic act, logic [BEMF_W-1:0] bemf);
        commutation_t       res;
        logic [BEMF_W-1:0]  watch;
        logic [BEMF_W-1:0]  level;
        logic [2:0]         hall;
        logic [DELAY_W-1:0] half;
        res.commutated = 1'b0;
        if (act == ACT_TICK) begin
            if (rotor_ticks != '1) rotor_ticks = rotor_ticks + 1'b1;
        end else if (rotor_pos >= bbsc_pkg::POS_FIRST && rotor_pos <= bbsc_pkg::POS_LAST) begin
            watch = ccw_sel ? bbsc_pkg::CCW_MASK[rotor_pos] : bbsc_pkg::CW_MASK[rotor_pos];
            level = ccw_sel ? bbsc_pkg::CCW_LEVEL[rotor_pos] : bbsc_pkg::CW_LEVEL[rotor_pos];
            if ((bemf & watch) == level) begin
                hall = bbsc_pkg::HALL_MAP[rotor_pos];
                rotor_drive = ccw_sel ? bbsc_pkg::REV_PHASE[hall] : bbsc_pkg::FWD_PHASE[hall];
                rotor_pos = (rotor_pos == bbsc_pkg::POS_LAST) ? bbsc_pkg::POS_FIRST
                                                              : rotor_pos + 1'b1;
                if (rotor_ticks > bbsc_pkg::ELAPSED_CLAMP)
                    half = DELAY_W'(bbsc_pkg::ELAPSED_CLAMP / 2);
                else
                    half = DELAY_W'(rotor_ticks >> 1);
                if (rotor_delay < half) rotor_delay = rotor_delay + 1'b1;
                if (rotor_delay > half && rotor_delay > 1) rotor_delay = rotor_delay - 1'b1;
                rotor_ticks = '0;
                res.commutated = 1'b1;
            end
        end
        res.drive_step     = rotor_drive;
        res.rotor_position = rotor_pos;
        res.delay_estimate = rotor_delay;
        res.duty_out       = duty_reg;
        return res;
    endfunction

    // comparator sample that meets (or misses) the level the current position waits for
    function automatic logic [BEMF_W-1:0] bemf_for(logic hit);
        logic [BEMF_W-1:0] watch;
        logic [BEMF_W-1:0] level;
        logic [BEMF_W-1:0] bits;
        watch = ccw_sel ? bbsc_pkg::CCW_MASK[rotor_pos] : bbsc_pkg::CW_MASK[rotor_pos];
        level = ccw_sel ? bbsc_pkg::CCW_LEVEL[rotor_pos] : bbsc_pkg::CW_LEVEL[rotor_pos];
        bits  = BEMF_W'($urandom_range(0, 7));
        return (bits & ~watch) | (hit ? level : (~level & watch));
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fault_count++;
        end
    endfunction

    task automatic send_item(input logic act, input logic [BEMF_W-1:0] bemf);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(8 - BEMF_W){1'b0}}, bemf};
        do @(posedge aclk); while (!s_tready);
        commutation_q.push_back(advance_rotor(act, bemf));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (commutation_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == bbsc_pkg::CFG_DIRECTION) ccw_sel = val[0];
        else if (idx == bbsc_pkg::CFG_DUTY_LEVEL) duty_reg = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_direction(input logic ccw);
        write_reg(bbsc_pkg::CFG_DIRECTION, {9'($urandom_range(0, 511)), ccw});
    endtask

    // mostly ticks followed by the awaited edge, with some stray samples and noise
    task automatic run_rotation(input int count, input int tick_lo, input int tick_hi);
        int sent;
        int ticks;
        int misses;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 7) begin
                ticks  = $urandom_range(tick_lo, tick_hi);
                misses = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (ticks) send_item(ACT_TICK, BEMF_W'($urandom_range(0, 7)));
                repeat (misses) send_item(ACT_SAMPLE, bemf_for(1'b0));
                send_item(ACT_SAMPLE, bemf_for(1'b1));
                sent += ticks + 1;
            end else begin
                send_item(1'($urandom_range(0, 1)), BEMF_W'($urandom_range(0, 7)));
                sent++;
            end
        end
    endtask

    task automatic test_reset_values();
        send_item(ACT_TICK, BEMF_W'($urandom_range(0, 7)));
        send_item(ACT_SAMPLE, bemf_for(1'b0));
    endtask

    task automatic test_clockwise_sequence();
        repeat (6) begin
            send_item(ACT_SAMPLE, bemf_for(1'b0));
            send_item(ACT_SAMPLE, bemf_for(1'b1));
        end
    endtask

    task automatic test_counter_clockwise_sequence();
        write_reg(bbsc_pkg::CFG_DIRECTION, {9'h1FF, 1'b1});
        send_item(ACT_SAMPLE, bemf_for(1'b0));
        repeat (6) send_item(ACT_SAMPLE, bemf_for(1'b1));
    endtask

    task automatic test_register_writes();
        write_reg(bbsc_pkg::CFG_DUTY_LEVEL, '0);
        send_item(ACT_SAMPLE, bemf_for(1'b1));
        write_reg(bbsc_pkg::CFG_DUTY_LEVEL, '1);
        write_reg(CFG_IDX_W'($urandom_range(bbsc_pkg::CFG_DUTY_LEVEL + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  DUTY_W'($urandom_range(0, 1023)));
        send_item(ACT_TICK, BEMF_W'($urandom_range(0, 7)));
        send_item(ACT_SAMPLE, bemf_for(1'b1));
    endtask

    task automatic test_tick_saturation();
        set_direction(1'b0);
        repeat (300) send_item(ACT_TICK, BEMF_W'($urandom_range(0, 7)));
        send_item(ACT_SAMPLE, bemf_for(1'b1));
        send_item(ACT_SAMPLE, bemf_for(1'b1));
    endtask

    task automatic test_result_backpressure();
        wait_idle();
        hold_req = 1'b1;
        wait (hold_active);
        no_gaps = 1'b1;
        run_rotation(40, 0, 4);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_rotation();
        set_direction(1'b0);
        write_reg(bbsc_pkg::CFG_DUTY_LEVEL, DUTY_W'($urandom_range(0, 1023)));
        run_rotation(200, 0, 50);
        set_direction(1'b1);
        write_reg(bbsc_pkg::CFG_DUTY_LEVEL, '1);
        run_rotation(180, 0, 3);
        set_direction(1'b0);
        write_reg(bbsc_pkg::CFG_DUTY_LEVEL, '0);
        no_gaps = 1'b1;
        run_rotation(150, 30, 90);
        no_gaps = 1'b0;
        set_direction(1'b1);
        write_reg(bbsc_pkg::CFG_DUTY_LEVEL, DUTY_W'($urandom_range(0, 1023)));
        run_rotation(180, 0, 60);
    endtask

    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else begin
                gap = no_gaps ? 0 : pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        commutation_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (commutation_q.size() == 0) begin
                $display("%0t: result item with no expectation, expected none, actual %h/%h",
                         $time, m_tuser, m_tdata);
                fault_count++;
            end else begin
                want = commutation_q.pop_front();
                check_field("commutated", 32'(want.commutated), 32'(m_tuser[0]));
                check_field("drive_step", 32'(want.drive_step), 32'(m_tdata[2:0]));
                check_field("rotor_position", 32'(want.rotor_position), 32'(m_tdata[5:3]));
                check_field("delay_estimate", 32'(want.delay_estimate), 32'(m_tdata[13:6]));
                check_field("duty_out", 32'(want.duty_out), 32'(m_tdata[23:14]));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_clockwise_sequence();
        test_counter_clockwise_sequence();
        test_register_writes();
        test_tick_saturation();
        test_result_backpressure();
        test_random_rotation();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (fault_count == 0 && commutation_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
